/* sv/spsp_pkg.sv */
// ----------------------------------------------------------------------------
// space packet stream parser package
// result kinds, parser phases and primary header field unpacking
// ----------------------------------------------------------------------------
package spsp_pkg;

   localparam int unsigned SEC_HEADER_BYTES = 7;
   localparam int unsigned PRI_HEADER_BYTES = 6;

   localparam logic [1:0] KIND_PRI  = 2'd0;
   localparam logic [1:0] KIND_SEC  = 2'd1;
   localparam logic [1:0] KIND_USER = 2'd2;

   localparam logic [1:0] PHASE_PRI  = 2'd0;
   localparam logic [1:0] PHASE_SEC  = 2'd1;
   localparam logic [1:0] PHASE_DATA = 2'd2;

   localparam logic [2:0] PRI_LAST_INDEX = 3'(PRI_HEADER_BYTES - 1);
   localparam logic [2:0] SEC_LAST_INDEX = 3'(SEC_HEADER_BYTES - 1);
   localparam logic [16:0] SEC_BYTES_17 = 17'(SEC_HEADER_BYTES);

   typedef struct packed {
      logic [2:0]  pkt_version;
      logic        pkt_type;
      logic        sec_flag;
      logic [10:0] apid;
      logic [1:0]  segment_flags;
      logic [13:0] seq_count;
      logic [15:0] data_length;
   } pri_header_type;

   function automatic pri_header_type unpack_header(input logic [47:0] hdr);
      pri_header_type h;
      h.pkt_version   = hdr[47:45];
      h.pkt_type      = hdr[44];
      h.sec_flag      = hdr[43];
      h.apid          = hdr[42:32];
      h.segment_flags = hdr[31:30];
      h.seq_count     = hdr[29:16];
      h.data_length   = hdr[15:0];
      return h;
   endfunction

endpackage

/* sv/space_packet_stream_parser.sv */
// ----------------------------------------------------------------------------
// space packet stream parser
// splits a byte stream of back-to-back space packets into header and data results
// ----------------------------------------------------------------------------
// usage
//   req_ channel: one stream byte per transfer, in packet order
//   rsp_ channel: one result per primary header, per secondary header and
//     per user data byte; header bytes being collected give no result
//   result: registered, shown in the cycle after the byte that completes it
//   throughput: one byte per cycle while req_ready is high; the parser state and the
//     result register are updated in the cycle a byte is taken
//   stall: the result register holds while rsp_ready is low, and req_ready
//     drops only when that register is full and not being emptied, so
//     header bytes flow on as soon as the pending result leaves
//   reset: synchronous; the parser restarts on a primary header and the
//     result register is emptied
//   header fields are repeated on every result of a packet; epoch and
//     sw_version are zero unless kind is the secondary header, user_byte is
//     zero unless kind is a user data byte
// ----------------------------------------------------------------------------
module space_packet_stream_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_pkt_version,
   output logic        rsp_pkt_type,
   output logic        rsp_sec_flag,
   output logic [10:0] rsp_apid,
   output logic [1:0]  rsp_segment_flags,
   output logic [13:0] rsp_seq_count,
   output logic [15:0] rsp_data_length,
   output logic [31:0] rsp_epoch,
   output logic [23:0] rsp_sw_version,
   output logic [7:0]  rsp_user_byte,
   output logic        rsp_last
);

   logic [1:0]  phase_ff, phase_in;
   logic [2:0]  idx_ff, idx_in;
   logic [47:0] hdr_ff, hdr_in;
   logic [55:0] sec_ff, sec_in;
   logic [16:0] rem_ff, rem_in;

   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff, kind_in;
   spsp_pkg::pri_header_type fields_ff, fields_in;
   logic [31:0] epoch_ff, epoch_in;
   logic [23:0] swv_ff, swv_in;
   logic [7:0]  user_ff, user_in;
   logic        last_ff, last_in;

   logic        take;
   logic        emit;
   logic [47:0] hdr_shifted;
   logic [55:0] sec_shifted;
   logic [16:0] total;

   assign req_ready   = !valid_ff || rsp_ready;
   assign take        = req_valid && req_ready;
   assign hdr_shifted = {hdr_ff[39:0], req_stream_byte};
   assign sec_shifted = {sec_ff[47:0], req_stream_byte};
   assign total       = {1'b0, hdr_ff[15:0]} + 17'd1;

   always_comb begin
      phase_in  = phase_ff;
      idx_in    = idx_ff;
      hdr_in    = hdr_ff;
      sec_in    = sec_ff;
      rem_in    = rem_ff;
      emit      = 1'b0;
      kind_in   = kind_ff;
      fields_in = fields_ff;
      epoch_in  = epoch_ff;
      swv_in    = swv_ff;
      user_in   = user_ff;
      last_in   = last_ff;
      if (take) begin
         case (phase_ff)
            spsp_pkg::PHASE_SEC: begin
               sec_in = sec_shifted;
               if (idx_ff < spsp_pkg::SEC_LAST_INDEX) begin
                  idx_in = idx_ff + 3'd1;
               end else begin
                  idx_in    = 3'd0;
                  emit      = 1'b1;
                  kind_in   = spsp_pkg::KIND_SEC;
                  fields_in = spsp_pkg::unpack_header(hdr_ff);
                  epoch_in  = sec_shifted[55:24];
                  swv_in    = sec_shifted[23:0];
                  user_in   = 8'd0;
                  if (total > spsp_pkg::SEC_BYTES_17) begin
                     rem_in   = total - spsp_pkg::SEC_BYTES_17;
                     phase_in = spsp_pkg::PHASE_DATA;
                     last_in  = 1'b0;
                  end else begin
                     rem_in   = 17'd0;
                     phase_in = spsp_pkg::PHASE_PRI;
                     last_in  = 1'b1;
                  end
               end
            end
            spsp_pkg::PHASE_DATA: begin
               emit      = 1'b1;
               kind_in   = spsp_pkg::KIND_USER;
               fields_in = spsp_pkg::unpack_header(hdr_ff);
               epoch_in  = 32'd0;
               swv_in    = 24'd0;
               user_in   = req_stream_byte;
               if (rem_ff <= 17'd1) begin
                  rem_in   = 17'd0;
                  phase_in = spsp_pkg::PHASE_PRI;
                  last_in  = 1'b1;
               end else begin
                  rem_in  = rem_ff - 17'd1;
                  last_in = 1'b0;
               end
            end
            default: begin
               phase_in = spsp_pkg::PHASE_PRI;
               hdr_in   = hdr_shifted;
               if (idx_ff < spsp_pkg::PRI_LAST_INDEX) begin
                  idx_in = idx_ff + 3'd1;
               end else begin
                  idx_in    = 3'd0;
                  emit      = 1'b1;
                  kind_in   = spsp_pkg::KIND_PRI;
                  fields_in = spsp_pkg::unpack_header(hdr_shifted);
                  epoch_in  = 32'd0;
                  swv_in    = 24'd0;
                  user_in   = 8'd0;
                  last_in   = 1'b0;
                  if (hdr_shifted[43]) begin
                     phase_in = spsp_pkg::PHASE_SEC;
                     sec_in   = 56'd0;
                     rem_in   = 17'd0;
                  end else begin
                     phase_in = spsp_pkg::PHASE_DATA;
                     rem_in   = {1'b0, hdr_shifted[15:0]} + 17'd1;
                  end
               end
            end
         endcase
      end
      valid_in = emit || (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= spsp_pkg::PHASE_PRI;
         idx_ff   <= 3'd0;
         hdr_ff   <= 48'd0;
         sec_ff   <= 56'd0;
         rem_ff   <= 17'd0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         hdr_ff   <= hdr_in;
         sec_ff   <= sec_in;
         rem_ff   <= rem_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      fields_ff <= fields_in;
      epoch_ff  <= epoch_in;
      swv_ff    <= swv_in;
      user_ff   <= user_in;
      last_ff   <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_pkt_version   = fields_ff.pkt_version;
   assign rsp_pkt_type      = fields_ff.pkt_type;
   assign rsp_sec_flag      = fields_ff.sec_flag;
   assign rsp_apid          = fields_ff.apid;
   assign rsp_segment_flags = fields_ff.segment_flags;
   assign rsp_seq_count     = fields_ff.seq_count;
   assign rsp_data_length   = fields_ff.data_length;
   assign rsp_epoch         = epoch_ff;
   assign rsp_sw_version    = swv_ff;
   assign rsp_user_byte     = user_ff;
   assign rsp_last          = last_ff;

endmodule
